>>> rtl/core/b2da_pkg.sv
`timescale 1ns / 1ps

package b2da_pkg;

  // Fixed field widths
  localparam int VALUE_W = 32;
  localparam int DIGITS  = 10;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int CNT_W   = $clog2(VALUE_W);
  localparam int IDX_W   = $clog2(DIGITS);
  localparam int CHAR_W  = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;
  localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(VALUE_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } b2da_state_t;

  // Index of the most significant nonzero BCD digit; zero when all digits are zero
  function automatic logic [IDX_W-1:0] msd_index(input logic [BCD_W-1:0] bcd);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/core/b2da_step.sv
`timescale 1ns / 1ps

// One double-dabble step: add-3 correction on every BCD digit, then shift
// the binary MSB into the BCD register.
module b2da_step
  import b2da_pkg::*;
(
  input  logic [VALUE_W-1:0] bin,
  input  logic [BCD_W-1:0]   bcd,
  output logic [VALUE_W-1:0] bin_out,
  output logic [BCD_W-1:0]   bcd_out
);

  logic [BCD_W-1:0] bcd_adj;

  // Per-digit correction, digits are independent
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Shift the combined register left by one
  assign bcd_out = {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
  assign bin_out = {bin[VALUE_W-2:0], 1'b0};

endmodule

>>> rtl/core/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Converts a 32-bit unsigned value to decimal ASCII digits, most significant
// first, leading zeros suppressed (zero gives a single '0'). A transfer in
// happens when start is high while busy is low. The value is converted by 32
// double-dabble steps through one shared shift/add-3 unit, one step per cycle,
// then its n digits (1 to 10) are presented one per cycle with strobe high,
// last_digit marking the final one. Results cannot be stalled: each digit is
// valid for exactly the cycle its strobe is high. busy drops during the last
// digit, so the next value can already be accepted while that digit is out.
module binary_to_decimal_ascii
  import b2da_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [VALUE_W-1:0] value,
  output logic              strobe,
  output logic [CHAR_W-1:0] digit_char,
  output logic              last_digit
);

  b2da_state_t      state, state_next;
  logic [VALUE_W-1:0] bin, bin_next;
  logic [BCD_W-1:0]   bcd, bcd_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [VALUE_W-1:0] step_bin;
  logic [BCD_W-1:0]   step_bcd;
  logic [3:0]         nib;

  // Shared conversion unit
  b2da_step u_step (
    .bin     (bin),
    .bcd     (bcd),
    .bin_out (step_bin),
    .bcd_out (step_bcd)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    bin <= bin_next;
    bcd <= bcd_next;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    bin_next   = bin;
    bcd_next   = bcd;
    cnt_next   = cnt;
    idx_next   = idx;
    case (state)
      ST_IDLE: begin
        if (start) begin
          bin_next   = value;
          bcd_next   = '0;
          cnt_next   = '0;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        bin_next = step_bin;
        bcd_next = step_bcd;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          idx_next   = msd_index(step_bcd);
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (idx == '0) begin
          if (start) begin
            bin_next   = value;
            bcd_next   = '0;
            cnt_next   = '0;
            state_next = ST_CONV;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          idx_next = idx - 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  assign nib        = bcd[{idx, 2'b00} +: 4];
  assign busy       = (state == ST_CONV) || ((state == ST_EMIT) && (idx != '0));
  assign strobe     = (state == ST_EMIT);
  assign digit_char = ASCII_ZERO + {2'b00, nib};
  assign last_digit = (idx == '0);

endmodule

>>> rtl/core/b2da_checker.sv
`timescale 1ns / 1ps

module b2da_checker
  import b2da_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input logic [CHAR_W-1:0] digit_char,
  input logic              last_digit
);

  // An accepted value starts a conversion
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy not raised after transfer in");

  // Conversion time separates transfer in from the first digit
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> !strobe)
    else $error("digit right after transfer in");

  // Only decimal digit codes are emitted
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + 6'd9))
    else $error("digit_char out of range");

  // A run ends only on its flagged digit
  assert property (@(posedge clk) disable iff (rst) $fell(strobe) |-> $past(last_digit))
    else $error("digit run ended without last_digit");

  // The flagged digit closes the run
  assert property (@(posedge clk) disable iff (rst) (strobe && last_digit) |=> !strobe)
    else $error("digit after last_digit");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .digit_char (digit_char),
  .last_digit (last_digit)
);

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import b2da_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 480;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [VALUE_W-1:0] RADIX = 10;

  // One expected digit of the decimal text
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [VALUE_W-1:0] value = '0;
  logic              strobe;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  logic [VALUE_W-1:0] values_to_send [$];
  digit_t             expected_digits [$];
  logic               taken = 1'b0;
  int                 burst_left = 1;
  int                 gap_left = 0;
  int                 errors = 0;
  int                 cycles = 0;

  binary_to_decimal_ascii dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  always #10 clk = ~clk;

  // Decimal digits of v, most significant first, leading zeros dropped
  task automatic predict_digits(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] rest;
    logic [3:0]         rev [DIGITS];
    int                 n;
    digit_t             d;
    rest = v;
    n = 0;
    do begin
      rev[n] = 4'(rest % RADIX);
      rest = rest / RADIX;
      n++;
    end while (rest != 0 && n < DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      d.ch   = ASCII_ZERO + CHAR_W'(rev[k]);
      d.last = (k == 0);
      expected_digits.push_back(d);
    end
  endtask

  // Random value: uniform, a random digit count, tiny, or near a power of ten
  function automatic logic [VALUE_W-1:0] random_value();
    longint      lo;
    longint      hi;
    longint      p;
    int          k;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return $urandom;
    end else if (sel < 8) begin
      k = $urandom_range(1, DIGITS);
      p = 1;
      for (int i = 1; i < k; i++) p = p * RADIX;
      lo = (k == 1) ? 0 : p;
      hi = p * RADIX - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      return VALUE_W'(lo + $urandom_range(0, int'(hi - lo)));
    end else if (sel == 8) begin
      return $urandom_range(0, 20);
    end else begin
      k = $urandom_range(1, DIGITS - 1);
      p = 1;
      for (int i = 0; i < k; i++) p = p * RADIX;
      return VALUE_W'(p + longint'($urandom_range(0, 2)) - 1);
    end
  endfunction

  // Driver: offers one value per transfer, in bursts separated by gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
        value    <= $urandom;
      end else if (values_to_send.size() > 0) begin
        start <= 1'b1;
        value <= values_to_send.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
        value <= $urandom;
      end
    end
  end

  // Monitor: predicts on each accepted value, checks each strobed digit
  always @(posedge clk) begin : monitor
    digit_t want;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (strobe) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected digit char=%h last=%b", $time, digit_char, last_digit);
          errors++;
        end else begin
          want = expected_digits.pop_front();
          if (digit_char !== want.ch) begin
            $display("%0t: digit_char expected %h actual %h", $time, want.ch, digit_char);
            errors++;
          end
          if (last_digit !== want.last) begin
            $display("%0t: last_digit expected %b actual %b", $time, want.last, last_digit);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        predict_digits(value);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [VALUE_W-1:0] corner [$];
    corner = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999999999,
               32'd1000000000, 32'd1000000001, 32'd4294967295, 32'd4294967294,
               32'd4294967290, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
               32'hAAAA_AAAA, 32'd1234567890, 32'd100000, 32'd99999, 32'd0,
               32'd7, 32'd4000000000};
    foreach (corner[i]) values_to_send.push_back(corner[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) values_to_send.push_back(random_value());

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until every value is transferred and every digit has come out
    @(posedge clk);
    while (values_to_send.size() > 0 || start || expected_digits.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> binary_to_decimal_ascii.f
rtl/core/b2da_pkg.sv
rtl/core/b2da_step.sv
rtl/core/binary_to_decimal_ascii.sv
rtl/core/b2da_checker.sv
test/tb.sv
